FILE: hw/rtl/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked on clk_i, off while rst_ni is low
`define SDE_ASSERT_IMP(lbl, pre, post) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) \
    else $error("sde port check failed");

// next-cycle implication, checked on clk_i, off while rst_ni is low
`define SDE_ASSERT_NXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error("sde port check failed");

`endif

FILE: hw/rtl/sde_pkg.sv
`timescale 1ns / 1ps

package sde_pkg;

  // input and result items
  typedef struct packed {
    logic [31:0] message_word;
    logic [2:0]  valid_bytes;
    logic        last_word;
  } sde_in_t;

  typedef struct packed {
    logic [63:0] digest_part;
    logic [1:0]  part_index;
    logic        last_part;
  } sde_out_t;

  // eight 32-bit words, index 0 is word a / h0
  typedef logic [0:7][31:0] sde_words_t;

  localparam sde_words_t HashInit = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [0:63][31:0] RoundK = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  localparam logic [31:0] PadMark   = 32'h8000_0000;
  localparam logic [5:0]  LenOffset = 6'd56;
  localparam logic [5:0]  LastRound = 6'd63;
  localparam logic [1:0]  LastPart  = 2'd3;
  localparam logic [2:0]  WordBytes = 3'd4;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DATA,
    S_MARK,
    S_ZERO,
    S_LEN_HI,
    S_LEN_LO,
    S_ROUND,
    S_ADD,
    S_OUT
  } sde_state_e;

  typedef enum logic [1:0] {
    LOAD_NONE,
    LOAD_MARK,
    LOAD_LEN_HI,
    LOAD_LEN_LO
  } sde_load_e;

  // datapath status seen by the sequencer
  typedef struct packed {
    logic [5:0] fill;
    logic [2:0] pend_cnt;
    logic       last;
  } sde_stat_t;

  // sequencer commands to the datapath
  typedef struct packed {
    logic       busy;
    logic       accept;
    logic       ins_en;
    logic [2:0] ins_n;
    logic       ins_zero;
    sde_load_e  load;
    logic       init_vars;
    logic       rnd_en;
    logic [5:0] rnd;
    logic       add_en;
    logic       out_valid;
    logic [1:0] part;
    logic       clear;
  } sde_ctl_t;

endpackage

FILE: hw/rtl/sde_round.sv
`timescale 1ns / 1ps

module sde_round (
  input  sde_pkg::sde_words_t vars_i,
  input  logic [31:0]         w0_i,
  input  logic [31:0]         w1_i,
  input  logic [31:0]         w9_i,
  input  logic [31:0]         w14_i,
  input  logic [31:0]         k_i,
  output sde_pkg::sde_words_t vars_o,
  output logic [31:0]         w_new_o
);

  function automatic logic [31:0] rotr(input logic [31:0] x, input logic [4:0] n);
    return (x >> n) | (x << (6'd32 - {1'b0, n}));
  endfunction

  logic [31:0] big_s1, big_s0, ch, maj, t1, t2;
  logic [31:0] sig0, sig1;

  always_comb begin
    big_s1 = rotr(vars_i[4], 5'd6) ^ rotr(vars_i[4], 5'd11) ^ rotr(vars_i[4], 5'd25);
    ch     = (vars_i[4] & vars_i[5]) ^ (~vars_i[4] & vars_i[6]);
    t1     = vars_i[7] + big_s1 + ch + k_i + w0_i;
    big_s0 = rotr(vars_i[0], 5'd2) ^ rotr(vars_i[0], 5'd13) ^ rotr(vars_i[0], 5'd22);
    maj    = (vars_i[0] & vars_i[1]) ^ (vars_i[0] & vars_i[2]) ^ (vars_i[1] & vars_i[2]);
    t2     = big_s0 + maj;

    vars_o[0] = t1 + t2;
    vars_o[1] = vars_i[0];
    vars_o[2] = vars_i[1];
    vars_o[3] = vars_i[2];
    vars_o[4] = vars_i[3] + t1;
    vars_o[5] = vars_i[4];
    vars_o[6] = vars_i[5];
    vars_o[7] = vars_i[6];

    // schedule word sixteen places ahead
    sig0    = rotr(w1_i, 5'd7) ^ rotr(w1_i, 5'd18) ^ (w1_i >> 3);
    sig1    = rotr(w14_i, 5'd17) ^ rotr(w14_i, 5'd19) ^ (w14_i >> 10);
    w_new_o = w0_i + sig0 + w9_i + sig1;
  end

endmodule

FILE: hw/rtl/sde_ctrl.sv
`timescale 1ns / 1ps

module sde_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                out_stall_i,
  input  sde_pkg::sde_stat_t  stat_i,
  output sde_pkg::sde_ctl_t   ctl_o
);

  sde_pkg::sde_state_e state_q, state_d, ret_q, ret_d;
  logic [5:0] rnd_q, rnd_d;
  logic [1:0] part_q, part_d;

  logic [6:0] room, gap, fill_new;
  logic [2:0] take, zero_n, n, cnt_left;
  logic       full, done, at_len;

  // byte counts for this cycle's insert
  always_comb begin
    room = 7'd64 - {1'b0, stat_i.fill};
    take = stat_i.pend_cnt;
    if ({4'b0, stat_i.pend_cnt} > room) begin
      take = room[2:0];
    end
    if (stat_i.fill <= sde_pkg::LenOffset) begin
      gap = {1'b0, sde_pkg::LenOffset} - {1'b0, stat_i.fill};
    end else begin
      gap = room;
    end
    zero_n = (gap > {4'b0, sde_pkg::WordBytes}) ? sde_pkg::WordBytes : gap[2:0];
    n        = (state_q == sde_pkg::S_ZERO) ? zero_n : take;
    fill_new = {1'b0, stat_i.fill} + {4'b0, n};
    full     = fill_new[6];
    cnt_left = stat_i.pend_cnt - take;
    done     = (cnt_left == 3'd0);
    at_len   = (stat_i.fill == sde_pkg::LenOffset);
  end

  // next state
  always_comb begin
    state_d = state_q;
    ret_d   = ret_q;
    rnd_d   = rnd_q;
    part_d  = part_q;
    case (state_q)
      sde_pkg::S_IDLE: begin
        if (in_valid_i) begin
          state_d = sde_pkg::S_DATA;
        end
      end
      sde_pkg::S_DATA, sde_pkg::S_MARK, sde_pkg::S_LEN_HI, sde_pkg::S_LEN_LO: begin
        if (full) begin
          state_d = sde_pkg::S_ROUND;
          ret_d   = state_q;
        end else if (done) begin
          case (state_q)
            sde_pkg::S_DATA: begin
              state_d = stat_i.last ? sde_pkg::S_MARK : sde_pkg::S_IDLE;
            end
            sde_pkg::S_MARK:   state_d = sde_pkg::S_ZERO;
            sde_pkg::S_LEN_HI: state_d = sde_pkg::S_LEN_LO;
            default:           state_d = sde_pkg::S_OUT;
          endcase
        end
      end
      sde_pkg::S_ZERO: begin
        if (at_len) begin
          state_d = sde_pkg::S_LEN_HI;
        end else if (full) begin
          state_d = sde_pkg::S_ROUND;
          ret_d   = sde_pkg::S_ZERO;
        end
      end
      sde_pkg::S_ROUND: begin
        rnd_d = rnd_q + 6'd1;
        if (rnd_q == sde_pkg::LastRound) begin
          state_d = sde_pkg::S_ADD;
        end
      end
      sde_pkg::S_ADD: begin
        state_d = ret_q;
      end
      sde_pkg::S_OUT: begin
        if (!out_stall_i) begin
          part_d = part_q + 2'd1;
          if (part_q == sde_pkg::LastPart) begin
            state_d = sde_pkg::S_IDLE;
          end
        end
      end
      default: state_d = sde_pkg::S_IDLE;
    endcase
  end

  // commands
  always_comb begin
    ctl_o           = '0;
    ctl_o.load      = sde_pkg::LOAD_NONE;
    ctl_o.busy      = (state_q != sde_pkg::S_IDLE);
    ctl_o.rnd       = rnd_q;
    ctl_o.part      = part_q;
    ctl_o.ins_n     = n;
    case (state_q)
      sde_pkg::S_IDLE: begin
        ctl_o.accept = in_valid_i;
      end
      sde_pkg::S_DATA, sde_pkg::S_MARK, sde_pkg::S_LEN_HI, sde_pkg::S_LEN_LO: begin
        ctl_o.ins_en    = 1'b1;
        ctl_o.init_vars = full;
        if (!full && done) begin
          if (state_q == sde_pkg::S_DATA && stat_i.last) begin
            ctl_o.load = sde_pkg::LOAD_MARK;
          end else if (state_q == sde_pkg::S_LEN_HI) begin
            ctl_o.load = sde_pkg::LOAD_LEN_LO;
          end
        end
      end
      sde_pkg::S_ZERO: begin
        if (at_len) begin
          ctl_o.load = sde_pkg::LOAD_LEN_HI;
        end else begin
          ctl_o.ins_en    = 1'b1;
          ctl_o.ins_zero  = 1'b1;
          ctl_o.init_vars = full;
        end
      end
      sde_pkg::S_ROUND: begin
        ctl_o.rnd_en = 1'b1;
      end
      sde_pkg::S_ADD: begin
        ctl_o.add_en = 1'b1;
      end
      sde_pkg::S_OUT: begin
        ctl_o.out_valid = 1'b1;
        ctl_o.clear     = !out_stall_i && (part_q == sde_pkg::LastPart);
      end
      default: ctl_o.busy = 1'b1;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= sde_pkg::S_IDLE;
      ret_q   <= sde_pkg::S_IDLE;
      rnd_q   <= '0;
      part_q  <= '0;
    end else begin
      state_q <= state_d;
      ret_q   <= ret_d;
      rnd_q   <= rnd_d;
      part_q  <= part_d;
    end
  end

endmodule

FILE: hw/rtl/sha256_digest_engine.sv
`timescale 1ns / 1ps
// sha-256 hasher for a message streamed as big-endian 32-bit words
// input channel: in_valid_i / in_stall_o with in_data_i; an item is taken when
//   valid is high and stall is low. valid_bytes says how many leading bytes
//   count (values above 4 act as 4); last_word closes the message
// output channel: out_valid_o / out_stall_i with out_data_o; four items per
//   message, digest most significant part first, last_part on the fourth
// word handling: a word that does not close a 64-byte block is inserted and the
//   block goes idle for the next; the word that closes one also runs the vars load,
//   64 rounds on the single shared round unit at one round per cycle, and the hash
//   add, and no new word is taken until all of that is done
// closing the message: the pad mark, zero fill of up to 4 bytes per step and the
//   two length words go in, with one or two extra compressions, then the digest
// in_stall_o stays high from the accepted item until the block is idle again,
//   including while the digest waits on out_stall_i; a stalled digest item
//   holds its value
// reset: hash words go to the standard initial values, length and fill clear,
//   and the block comes up idle with no digest pending

module sha256_digest_engine (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  sde_pkg::sde_in_t  in_data_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output sde_pkg::sde_out_t out_data_o
);

  sde_pkg::sde_ctl_t  ctl;
  sde_pkg::sde_stat_t stat;

  // block buffer, byte 0 of the block lands at the top; during rounds it is
  // the 16-word schedule window, w[i] on top
  logic [511:0]        buf_q, buf_d;
  logic [31:0]         pend_q, pend_d;     // bytes waiting to go in, left aligned
  logic [2:0]          pend_cnt_q, pend_cnt_d;
  logic                last_q, last_d;
  logic [5:0]          fill_q, fill_d;
  logic [63:0]         bits_q, bits_d;
  sde_pkg::sde_words_t hash_q, hash_d;
  sde_pkg::sde_words_t vars_q, vars_d;

  sde_pkg::sde_words_t rnd_vars;
  logic [31:0]         w_new;
  logic [31:0]         src;
  logic [2:0]          in_cnt;

  assign stat.fill     = fill_q;
  assign stat.pend_cnt = pend_cnt_q;
  assign stat.last     = last_q;

  sde_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .out_stall_i (out_stall_i),
    .stat_i      (stat),
    .ctl_o       (ctl)
  );

  sde_round u_round (
    .vars_i  (vars_q),
    .w0_i    (buf_q[511:480]),
    .w1_i    (buf_q[479:448]),
    .w9_i    (buf_q[223:192]),
    .w14_i   (buf_q[63:32]),
    .k_i     (sde_pkg::RoundK[ctl.rnd]),
    .vars_o  (rnd_vars),
    .w_new_o (w_new)
  );

  always_comb begin
    buf_d      = buf_q;
    pend_d     = pend_q;
    pend_cnt_d = pend_cnt_q;
    last_d     = last_q;
    fill_d     = fill_q;
    bits_d     = bits_q;
    hash_d     = hash_q;
    vars_d     = vars_q;

    in_cnt = (in_data_i.valid_bytes > sde_pkg::WordBytes) ? sde_pkg::WordBytes
                                                          : in_data_i.valid_bytes;
    src    = ctl.ins_zero ? 32'h0 : pend_q;

    if (ctl.accept) begin
      pend_d     = in_data_i.message_word;
      pend_cnt_d = in_cnt;
      last_d     = in_data_i.last_word;
      bits_d     = bits_q + {58'b0, in_cnt, 3'b000};
    end

    // move up to four bytes into the block
    if (ctl.ins_en) begin
      case (ctl.ins_n)
        3'd1:    buf_d = {buf_q[503:0], src[31:24]};
        3'd2:    buf_d = {buf_q[495:0], src[31:16]};
        3'd3:    buf_d = {buf_q[487:0], src[31:8]};
        3'd4:    buf_d = {buf_q[479:0], src};
        default: buf_d = buf_q;
      endcase
      fill_d = fill_q + {3'b0, ctl.ins_n};
      if (!ctl.ins_zero) begin
        case (ctl.ins_n)
          3'd1:    pend_d = {pend_q[23:0], 8'h0};
          3'd2:    pend_d = {pend_q[15:0], 16'h0};
          3'd3:    pend_d = {pend_q[7:0], 24'h0};
          3'd4:    pend_d = 32'h0;
          default: pend_d = pend_q;
        endcase
        pend_cnt_d = pend_cnt_q - ctl.ins_n;
      end
    end

    // padding sources
    case (ctl.load)
      sde_pkg::LOAD_MARK: begin
        pend_d     = sde_pkg::PadMark;
        pend_cnt_d = 3'd1;
      end
      sde_pkg::LOAD_LEN_HI: begin
        pend_d     = bits_q[63:32];
        pend_cnt_d = sde_pkg::WordBytes;
      end
      sde_pkg::LOAD_LEN_LO: begin
        pend_d     = bits_q[31:0];
        pend_cnt_d = sde_pkg::WordBytes;
      end
      default: ;
    endcase

    if (ctl.init_vars) begin
      vars_d = hash_q;
    end

    // one round and one schedule step per cycle
    if (ctl.rnd_en) begin
      vars_d = rnd_vars;
      buf_d  = {buf_q[479:0], w_new};
    end

    if (ctl.add_en) begin
      for (int i = 0; i < 8; i++) begin
        hash_d[i] = hash_q[i] + vars_q[i];
      end
    end

    // digest taken: back to a fresh message
    if (ctl.clear) begin
      hash_d     = sde_pkg::HashInit;
      bits_d     = '0;
      fill_d     = '0;
      pend_cnt_d = '0;
      last_d     = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hash_q     <= sde_pkg::HashInit;
      bits_q     <= '0;
      fill_q     <= '0;
      pend_cnt_q <= '0;
      last_q     <= 1'b0;
    end else begin
      hash_q     <= hash_d;
      bits_q     <= bits_d;
      fill_q     <= fill_d;
      pend_cnt_q <= pend_cnt_d;
      last_q     <= last_d;
    end
  end

  // payload only, no reset
  always_ff @(posedge clk_i) begin
    buf_q  <= buf_d;
    pend_q <= pend_d;
    vars_q <= vars_d;
  end

  assign in_stall_o             = ctl.busy;
  assign out_valid_o            = ctl.out_valid;
  assign out_data_o.digest_part = {hash_q[{ctl.part, 1'b0}], hash_q[{ctl.part, 1'b1}]};
  assign out_data_o.part_index  = ctl.part;
  assign out_data_o.last_part   = (ctl.part == sde_pkg::LastPart);

endmodule

FILE: hw/rtl/sde_checker.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"

module sde_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_stall_o,
  input sde_pkg::sde_in_t  in_data_i,
  input logic              out_valid_o,
  input logic              out_stall_i,
  input sde_pkg::sde_out_t out_data_o
);

  // no word is taken while a digest is on the output
  `SDE_ASSERT_IMP(out_blocks_in, out_valid_o, in_stall_o)

  // a word that does not close the message gives no digest next cycle
  `SDE_ASSERT_NXT(word_no_digest, in_valid_i && !in_stall_o && !in_data_i.last_word, !out_valid_o)

  // a digest starts at its most significant part
  `SDE_ASSERT_IMP(first_part, $rose(out_valid_o), out_data_o.part_index == 2'd0)

  // parts follow one another without a gap
  `SDE_ASSERT_NXT(part_order, out_valid_o && !out_stall_i && !out_data_o.last_part, out_valid_o && (out_data_o.part_index == $past(out_data_o.part_index) + 2'd1))

  // stalled digest item holds
  `SDE_ASSERT_NXT(hold_on_stall, out_valid_o && out_stall_i, out_valid_o && $stable(out_data_o))

endmodule

bind sha256_digest_engine sde_checker u_sde_checker (.*);

FILE: dv/sha256_digest_engine_test.sv
`timescale 1ns / 1ps

module sha256_digest_engine_test;
  import sde_pkg::*;

  // run limits: the slowest correct run stays well below CycleLimit
  localparam int RandItems   = 260;
  localparam int DrainCycles = 300;
  localparam int CycleLimit  = 500000;
  localparam int DirRows     = 23;

  // one row of the directed table; digest is typed in only where known is set
  typedef struct packed {
    logic [31:0]  word;
    logic [2:0]   nbytes;
    logic         last;
    logic         known;
    logic [255:0] digest;
  } stim_row_t;

  logic     clk = 1'b0;
  logic     rst_n = 1'b0;
  logic     in_valid = 1'b0;
  sde_in_t  in_data = '0;
  logic     in_stall;
  logic     out_valid;
  logic     out_stall = 1'b0;
  sde_out_t out_data;

  sha256_digest_engine DUT (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data)
  );

  // predictor state: chaining value, partial block, fill and bit length
  logic [31:0] chain_h [8];
  logic [31:0] pend_block [16];
  int          pend_fill;
  logic [63:0] msg_bit_count;

  sde_out_t    digest_due [$];
  int          errors = 0;
  int          cycles = 0;
  int          words_sent = 0;
  bit          calm_in = 1'b0;
  bit          calm_out = 1'b0;
  stim_row_t   dir_rows [DirRows];

  initial begin
    forever #1 clk = ~clk;
  end

  // hard stop in case the block hangs
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  function automatic logic [31:0] sha_rotr(logic [31:0] v, int n);
    return (v >> n) | (v << (32 - n));
  endfunction

  function automatic void clear_hash_model();
    int i;
    for (i = 0; i < 8; i++) chain_h[i] = HashInit[i];
    for (i = 0; i < 16; i++) pend_block[i] = '0;
    pend_fill = 0;
    msg_bit_count = '0;
  endfunction

  // 64-round compression of pend_block into chain_h
  function automatic void compress_block();
    logic [31:0] sched [64];
    logic [31:0] v [8];
    logic [31:0] s0, s1, t1, t2;
    int i;
    for (i = 0; i < 16; i++) sched[i] = pend_block[i];
    for (i = 16; i < 64; i++) begin
      s0 = sha_rotr(sched[i-15], 7) ^ sha_rotr(sched[i-15], 18) ^ (sched[i-15] >> 3);
      s1 = sha_rotr(sched[i-2], 17) ^ sha_rotr(sched[i-2], 19) ^ (sched[i-2] >> 10);
      sched[i] = sched[i-16] + s0 + sched[i-7] + s1;
    end
    for (i = 0; i < 8; i++) v[i] = chain_h[i];
    for (i = 0; i < 64; i++) begin
      t1 = v[7] + (sha_rotr(v[4], 6) ^ sha_rotr(v[4], 11) ^ sha_rotr(v[4], 25))
         + ((v[4] & v[5]) ^ (~v[4] & v[6])) + RoundK[i] + sched[i];
      t2 = (sha_rotr(v[0], 2) ^ sha_rotr(v[0], 13) ^ sha_rotr(v[0], 22))
         + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
      v[7] = v[6];
      v[6] = v[5];
      v[5] = v[4];
      v[4] = v[3] + t1;
      v[3] = v[2];
      v[2] = v[1];
      v[1] = v[0];
      v[0] = t1 + t2;
    end
    for (i = 0; i < 8; i++) chain_h[i] = chain_h[i] + v[i];
  endfunction

  function automatic void absorb_byte(logic [7:0] b);
    int pos;
    pos = pend_fill;
    if (pos % 4 == 0) pend_block[pos / 4] = '0;
    pend_block[pos / 4][8 * (3 - pos % 4) +: 8] = b;
    pos++;
    if (pos == 64) begin
      compress_block();
      pos = 0;
    end
    pend_fill = pos;
  endfunction

  // takes one accepted item; on the last word pads and queues four digest parts
  function automatic void absorb_item(sde_in_t w, logic known, logic [255:0] typed);
    int          cnt;
    int          i;
    logic [63:0] total;
    sde_out_t    part;
    cnt = (w.valid_bytes > WordBytes) ? 4 : int'(w.valid_bytes);
    for (i = 0; i < cnt; i++) absorb_byte(w.message_word[8 * (3 - i) +: 8]);
    msg_bit_count = msg_bit_count + 64'(cnt * 8);
    if (w.last_word) begin
      total = msg_bit_count;
      absorb_byte(8'h80);
      while (pend_fill != 56) absorb_byte(8'h00);
      for (i = 0; i < 8; i++) absorb_byte(total[8 * (7 - i) +: 8]);
      for (i = 0; i < 4; i++) begin
        part.digest_part = known ? typed[255 - 64 * i -: 64] : {chain_h[2*i], chain_h[2*i+1]};
        part.part_index  = 2'(i);
        part.last_part   = (2'(i) == LastPart);
        digest_due.push_back(part);
      end
      clear_hash_model();
    end
  endfunction

  // called at a falling edge, returns at the falling edge after the handshake
  task automatic send_word(sde_in_t w, logic known, logic [255:0] typed);
    int gap;
    gap = calm_in ? 0 : $urandom_range(0, 19);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_data  <= w;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    absorb_item(w, known, typed);
    words_sent++;
    @(negedge clk);
  endtask

  // compares one accepted digest item with the oldest one due
  task automatic check_digest(sde_out_t got);
    sde_out_t want;
    if (digest_due.size() == 0) begin
      $error("digest item with none due: %h", got);
      errors++;
    end else begin
      want = digest_due.pop_front();
      if (got.digest_part !== want.digest_part) begin
        $error("digest_part: expected %h, got %h", want.digest_part, got.digest_part);
        errors++;
      end
      if (got.part_index !== want.part_index) begin
        $error("part_index: expected %0d, got %0d", want.part_index, got.part_index);
        errors++;
      end
      if (got.last_part !== want.last_part) begin
        $error("last_part: expected %0d, got %0d", want.last_part, got.last_part);
        errors++;
      end
    end
  endtask

  // digest receiver: random stall per item, with calm stretches of none
  initial begin
    int gap;
    @(posedge rst_n);
    @(negedge clk);
    forever begin
      if ($urandom_range(0, 15) == 0) calm_out = ~calm_out;
      gap = calm_out ? 0 : $urandom_range(0, 19);
      if (gap != 0) begin
        out_stall <= 1'b1;
        repeat (gap) @(negedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      check_digest(out_data);
      @(negedge clk);
    end
  end

  initial begin
    sde_in_t w;
    int      r;
    int      k;
    int      msg_len;

    // directed table
    dir_rows = '{
      // empty message right after reset
      {32'h0000_0000, 3'd0, 1'b1, 1'b1,
       256'he3b0c44298fc1c149afbf4c8996fb92427ae41e4649b934ca495991b7852b855},
      // "abc" in one partial last word
      {32'h6162_6300, 3'd3, 1'b1, 1'b1,
       256'hba7816bf8f01cfea414140de5dae2223b00361a396177a9cb410ff61f20015ad},
      // all ones with an oversized count on the last word
      {32'hffff_ffff, 3'd7, 1'b1, 1'b0, 256'h0},
      // partial and empty words before the end, byte stream runs on
      {32'hdead_beef, 3'd1, 1'b0, 1'b0, 256'h0},
      {32'h1234_5678, 3'd2, 1'b0, 1'b0, 256'h0},
      {32'hcafe_f00d, 3'd4, 1'b0, 1'b0, 256'h0},
      {32'h0000_0000, 3'd0, 1'b0, 1'b0, 256'h0},
      {32'ha5a5_a5a5, 3'd5, 1'b0, 1'b0, 256'h0},
      {32'h0102_0304, 3'd3, 1'b1, 1'b0, 256'h0},
      // 56 bytes: the length spills into a second padding block
      {32'h0001_0203, 3'd4, 1'b0, 1'b0, 256'h0},
      {32'h0405_0607, 3'd4, 1'b0, 1'b0, 256'h0},
      {32'h0809_0a0b, 3'd4, 1'b0, 1'b0, 256'h0},
      {32'h0c0d_0e0f, 3'd4, 1'b0, 1'b0, 256'h0},
      {32'h1011_1213, 3'd4, 1'b0, 1'b0, 256'h0},
      {32'h1415_1617, 3'd4, 1'b0, 1'b0, 256'h0},
      {32'h1819_1a1b, 3'd4, 1'b0, 1'b0, 256'h0},
      {32'h1c1d_1e1f, 3'd4, 1'b0, 1'b0, 256'h0},
      {32'h2021_2223, 3'd4, 1'b0, 1'b0, 256'h0},
      {32'h2425_2627, 3'd4, 1'b0, 1'b0, 256'h0},
      {32'h2829_2a2b, 3'd4, 1'b0, 1'b0, 256'h0},
      {32'h2c2d_2e2f, 3'd4, 1'b0, 1'b0, 256'h0},
      {32'h3031_3233, 3'd4, 1'b0, 1'b0, 256'h0},
      {32'h3435_3637, 3'd4, 1'b1, 1'b0, 256'h0}
    };

    clear_hash_model();
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    for (r = 0; r < DirRows; r++) begin
      w.message_word = dir_rows[r].word;
      w.valid_bytes  = dir_rows[r].nbytes;
      w.last_word    = dir_rows[r].last;
      send_word(w, dir_rows[r].known, dir_rows[r].digest);
    end

    // random messages: mostly short, some near the padding boundary, a few multi-block
    words_sent = 0;
    while (words_sent < RandItems) begin
      k = $urandom_range(0, 9);
      if (k == 0) msg_len = $urandom_range(30, 48);
      else if (k < 4) msg_len = $urandom_range(13, 18);
      else msg_len = $urandom_range(1, 12);
      calm_in = ($urandom_range(0, 3) == 0);
      for (k = 0; k < msg_len; k++) begin
        w.message_word = $urandom;
        w.last_word    = (k == msg_len - 1);
        // odd counts mostly on the closing word, now and then mid-message
        if (w.last_word || $urandom_range(0, 7) == 0) w.valid_bytes = 3'($urandom_range(0, 7));
        else w.valid_bytes = WordBytes;
        send_word(w, 1'b0, '0);
      end
    end
    in_valid <= 1'b0;

    // wait for every digest item, then watch for strays
    while (digest_due.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    if (errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

FILE: sha256_digest_engine.f
+incdir+hw/rtl
hw/rtl/sde_pkg.sv
hw/rtl/sde_round.sv
hw/rtl/sde_ctrl.sv
hw/rtl/sha256_digest_engine.sv
hw/rtl/sde_checker.sv
dv/sha256_digest_engine_test.sv
